// ===== rtl/dcsh_pkg.sv =====
// Shared constants, types and helper functions for the ducking channel strip.
package dcsh_pkg;

    // Storage sizing
    localparam int CHANNELS    = 16;
    localparam int DELAY_DEPTH = 2048;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W       = $clog2(DELAY_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Fixed-point constants (Q2.14 samples, 10 V = 16384)
    localparam int ONE_Q14        = 16384;
    localparam int ONE_Q28        = 1 << 28;
    localparam int TRIG_HIGH_CODE = 1639;
    localparam int LEVEL_MAX      = 32768;
    localparam int DUCK_MAX       = 16384;
    localparam int DPROD_W        = 29;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_GAIN    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DUCK_AMOUNT   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd2;

    // Configuration as seen by the datapath, already saturated and clamped
    typedef struct packed {
        logic [15:0]      level_gain;
        logic [14:0]      duck_amount;
        logic [PTR_W-1:0] delay;
    } cfg_t;

    // One classified word passed from the front end to the back end
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] chain_left;
        logic signed [15:0] chain_right;
        logic [DPROD_W-1:0] duck_prod;
        logic [14:0]        level_cv;
        logic               muted;
    } entry_t;

    // Clamp a control voltage to the range 0 .. 10 V (Q1.14).
    function automatic logic [14:0] clamp_cv(input logic signed [15:0] v);
        logic [14:0] r;
        if (v < 16'sd0)
            r = '0;
        else if (v > 16'sd16384)
            r = 15'(ONE_Q14);
        else
            r = v[14:0];
        return r;
    endfunction

    // Clamp the delay register to the usable length of a delay line.
    function automatic logic [PTR_W-1:0] clamp_delay(input logic [10:0] d);
        logic [PTR_W-1:0] r;
        if (d == 11'd0)
            r = PTR_W'(1);
        else if (int'(d) > DELAY_DEPTH - 1)
            r = PTR_W'(DELAY_DEPTH - 1);
        else
            r = PTR_W'(d);
        return r;
    endfunction

    // Saturate a sum to a 16-bit sample.
    function automatic logic signed [15:0] sat16(input logic signed [19:0] x);
        logic signed [15:0] r;
        if (x > 20'sd32767)
            r = 16'sh7FFF;
        else if (x < -20'sd32768)
            r = 16'sh8000;
        else
            r = x[15:0];
        return r;
    endfunction

endpackage

// ===== rtl/dcsh_queue.sv =====
// Small register queue between the front end and the back end.
module dcsh_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dcsh_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output dcsh_pkg::entry_t head,
    output logic            empty
);
    import dcsh_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    // Status and handshake qualification
    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer and count updates, wrapping at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/dcsh_front.sv =====
// Front end: accepts words, runs the mute trigger and the per-channel delay lines.
module dcsh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  dcsh_pkg::cfg_t     cfg,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         channel,
    input  logic signed [15:0] mute_trigger,
    input  logic signed [15:0] left_in,
    input  logic signed [15:0] right_in,
    input  logic signed [15:0] chain_left_in,
    input  logic signed [15:0] chain_right_in,
    input  logic signed [15:0] duck_cv,
    input  logic signed [15:0] level_cv,
    input  logic               use_delay,
    output logic               q_push,
    output dcsh_pkg::entry_t   q_entry,
    input  logic               q_full
);
    import dcsh_pkg::*;

    // Delay memory, one line per channel
    logic signed [15:0] dly_mem [CHANNELS][DELAY_DEPTH];

    // Per-channel write pointers and wrap marks; an entry is written once
    // its line has wrapped or it lies below the write pointer.
    logic [PTR_W-1:0]    wp_reg [CHANNELS];
    logic [CHANNELS-1:0] wrapped_reg;

    logic muted_reg, muted_next;
    logic trig_reg, trig_next;
    logic s1_valid_reg, s1_valid_next;

    logic             accept;
    logic             ch_ok;
    logic [CH_W-1:0]  ch_idx;
    logic [PTR_W-1:0] wp_cur, wp_next, rp;
    logic [PTR_W:0]   rp_wrap;
    logic             wrap;
    logic             rd_ok;
    logic             dly_wr;
    logic [DPROD_W-1:0] duck_prod;

    // Stage 1 payload
    logic signed [15:0] s1_left_reg, s1_right_reg;
    logic signed [15:0] s1_chain_l_reg, s1_chain_r_reg;
    logic [DPROD_W-1:0] s1_dprod_reg;
    logic [14:0]        s1_lcv_reg;
    logic               s1_muted_reg, s1_use_dly_reg, s1_rd_ok_reg;
    logic signed [15:0] rdata_reg;

    // Handshake: stage 1 holds a word until the queue takes it.
    assign q_push        = s1_valid_reg && !q_full;
    assign full          = s1_valid_reg && q_full;
    assign accept        = push && !full;
    assign s1_valid_next = accept || (s1_valid_reg && q_full);

    // Mute trigger, evaluated on channel 0 only
    always_comb
    begin
        trig_next  = trig_reg;
        muted_next = muted_reg;
        if (accept && (channel == 4'd0))
        begin
            if (trig_reg)
            begin
                if (mute_trigger <= 16'sd0)
                begin
                    trig_next = 1'b0;
                end
            end
            else if (mute_trigger >= 16'(TRIG_HIGH_CODE))
            begin
                trig_next  = 1'b1;
                muted_next = !muted_reg;
            end
        end
    end

    // Delay line addressing
    assign ch_ok   = (int'(channel) < CHANNELS);
    assign ch_idx  = channel[CH_W-1:0];
    assign wp_cur  = wp_reg[ch_idx];
    assign rp_wrap = {1'b0, wp_cur} + (PTR_W + 1)'(DELAY_DEPTH) - {1'b0, cfg.delay};
    assign rp      = (wp_cur >= cfg.delay) ? (wp_cur - cfg.delay) : rp_wrap[PTR_W-1:0];
    assign rd_ok   = ch_ok && (wrapped_reg[ch_idx] || (rp < wp_cur));
    assign wrap    = (wp_cur == PTR_W'(DELAY_DEPTH - 1));
    assign wp_next = wrap ? '0 : wp_cur + 1'b1;
    assign dly_wr  = accept && use_delay && ch_ok;

    // Duck depth product, Q1.28
    assign duck_prod = DPROD_W'(clamp_cv(duck_cv)) * DPROD_W'(cfg.duck_amount);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            muted_reg    <= 1'b0;
            trig_reg     <= 1'b0;
            wrapped_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            muted_reg    <= muted_next;
            trig_reg     <= trig_next;
            if (dly_wr)
            begin
                wp_reg[ch_idx] <= wp_next;
                if (wrap)
                begin
                    wrapped_reg[ch_idx] <= 1'b1;
                end
            end
        end
    end

    // Memory port and stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg      <= dly_mem[ch_idx][rp];
            s1_left_reg    <= left_in;
            s1_right_reg   <= right_in;
            s1_chain_l_reg <= chain_left_in;
            s1_chain_r_reg <= chain_right_in;
            s1_dprod_reg   <= duck_prod;
            s1_lcv_reg     <= clamp_cv(level_cv);
            s1_muted_reg   <= muted_next;
            s1_use_dly_reg <= use_delay;
            s1_rd_ok_reg   <= rd_ok;
        end
        if (dly_wr)
        begin
            dly_mem[ch_idx][wp_cur] <= left_in;
        end
    end

    // Right source: the delayed left sample, zero if never written, or right_in.
    always_comb
    begin
        q_entry.left        = s1_left_reg;
        q_entry.chain_left  = s1_chain_l_reg;
        q_entry.chain_right = s1_chain_r_reg;
        q_entry.duck_prod   = s1_dprod_reg;
        q_entry.level_cv    = s1_lcv_reg;
        q_entry.muted       = s1_muted_reg;
        if (s1_use_dly_reg)
        begin
            q_entry.right = s1_rd_ok_reg ? rdata_reg : 16'sd0;
        end
        else
        begin
            q_entry.right = s1_right_reg;
        end
    end

endmodule

// ===== rtl/dcsh_back.sv =====
// Back end: gain computation, scaling, chain sum and saturation.
module dcsh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  dcsh_pkg::cfg_t     cfg,
    input  logic               q_empty,
    output logic               q_pop,
    input  dcsh_pkg::entry_t   q_head,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               mute_led
);
    import dcsh_pkg::*;

    logic advance;
    logic b1_v_reg, b2_v_reg, b3_v_reg, out_v_reg;

    // Stage 1: sidechain factor and level product
    logic [29:0] trip;
    logic [28:0] sc28;
    logic [29:0] sc28_rnd;
    logic [30:0] lvl_prod;
    logic [14:0] b1_sc14_reg;
    logic [29:0] b1_plvl_reg;
    entry_t      b1_reg;

    // Stage 2: combined gain, Q2.28
    logic [29:0] plvl_rnd;
    logic [15:0] g14;
    logic [29:0] b2_gain_reg;
    entry_t      b2_reg;

    // Stage 3: lane products
    logic signed [46:0] b3_pl_reg, b3_pr_reg;
    entry_t             b3_reg;

    // Stage 4: rounding, mute and chain sum
    logic signed [46:0] pl_rnd, pr_rnd;
    logic signed [18:0] lsc, rsc;

    // The whole pipeline moves when the output register is free or popped.
    assign advance = !out_v_reg || pop;
    assign q_pop   = advance && !q_empty;
    assign empty   = !out_v_reg;

    assign trip     = 30'(q_head.duck_prod) + {q_head.duck_prod, 1'b0};
    assign sc28     = (trip >= 30'(ONE_Q28)) ? '0 : 29'(30'(ONE_Q28) - trip);
    assign sc28_rnd = 30'(sc28) + 30'(1 << 13);
    assign lvl_prod = 31'(cfg.level_gain) * 31'(q_head.level_cv);

    assign plvl_rnd = b1_plvl_reg + 30'(1 << 13);
    assign g14      = plvl_rnd[29:14];

    assign pl_rnd = b3_pl_reg + 47'sd134217728;
    assign pr_rnd = b3_pr_reg + 47'sd134217728;
    assign lsc    = b3_reg.muted ? 19'sd0 : pl_rnd[46:28];
    assign rsc    = b3_reg.muted ? 19'sd0 : pr_rnd[46:28];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            b3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_v_reg  <= !q_empty;
            b2_v_reg  <= b1_v_reg;
            b3_v_reg  <= b2_v_reg;
            out_v_reg <= b3_v_reg;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_reg      <= q_head;
            b1_sc14_reg <= sc28_rnd[28:14];
            b1_plvl_reg <= lvl_prod[29:0];

            b2_reg      <= b1_reg;
            b2_gain_reg <= 30'(g14) * 30'(b1_sc14_reg);

            b3_reg    <= b2_reg;
            b3_pl_reg <= 47'(b2_reg.left) * 47'($signed({1'b0, b2_gain_reg}));
            b3_pr_reg <= 47'(b2_reg.right) * 47'($signed({1'b0, b2_gain_reg}));

            left_out  <= sat16(20'(lsc) + 20'(b3_reg.chain_left));
            right_out <= sat16(20'(rsc) + 20'(b3_reg.chain_right));
            mute_led  <= b3_reg.muted;
        end
    end

endmodule

// ===== rtl/ducking_channel_strip_haas.sv =====
// Top level of the ducking channel strip: configuration registers and the two halves.
//
//   Channel   Handshake           Payload
//   input     push / full         channel, mute_trigger, left_in, right_in,
//                                 chain_left_in, chain_right_in, duck_cv,
//                                 level_cv, use_delay
//   result    empty / pop         left_out, right_out, mute_led
//   config    cfg_write_en        cfg_index, cfg_data
//
// One word is accepted per cycle while full is low; the delay memory takes one read and one
// write per cycle, and the back end pipeline issues one result per cycle while results are
// popped. A word passes stage 1, the queue, back end stages 1 to 3 and the output register.
// Reset clears the mute state, the write pointers and the per-channel wrap
// marks; delay entries not yet written read as zero, so no clearing pass runs.
// An unpopped result stalls the back end; once the queue fills, full rises.
module ducking_channel_strip_haas (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [3:0]                     channel,
    input  logic signed [15:0]             mute_trigger,
    input  logic signed [15:0]             left_in,
    input  logic signed [15:0]             right_in,
    input  logic signed [15:0]             chain_left_in,
    input  logic signed [15:0]             chain_right_in,
    input  logic signed [15:0]             duck_cv,
    input  logic signed [15:0]             level_cv,
    input  logic                           use_delay,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [15:0]             left_out,
    output logic signed [15:0]             right_out,
    output logic                           mute_led,
    input  logic                           cfg_write_en,
    input  logic [dcsh_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import dcsh_pkg::*;

    logic [15:0] level_gain_reg;
    logic [14:0] duck_amount_reg;
    logic [10:0] delay_samples_reg;
    cfg_t        cfg;

    logic   q_push, q_full, q_pop, q_empty;
    entry_t q_entry, q_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_gain_reg    <= 16'(ONE_Q14);
            duck_amount_reg   <= '0;
            delay_samples_reg <= 11'd960;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_LEVEL_GAIN:    level_gain_reg    <= cfg_data;
                REG_DUCK_AMOUNT:   duck_amount_reg   <= cfg_data[14:0];
                REG_DELAY_SAMPLES: delay_samples_reg <= cfg_data[10:0];
                default:           ;
            endcase
        end
    end

    // Saturated and clamped view of the registers
    always_comb
    begin
        cfg.level_gain  = (int'(level_gain_reg) > LEVEL_MAX) ? 16'(LEVEL_MAX) : level_gain_reg;
        cfg.duck_amount = (int'(duck_amount_reg) > DUCK_MAX) ? 15'(DUCK_MAX) : duck_amount_reg;
        cfg.delay       = clamp_delay(delay_samples_reg);
    end

    dcsh_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .push           (push),
        .full           (full),
        .channel        (channel),
        .mute_trigger   (mute_trigger),
        .left_in        (left_in),
        .right_in       (right_in),
        .chain_left_in  (chain_left_in),
        .chain_right_in (chain_right_in),
        .duck_cv        (duck_cv),
        .level_cv       (level_cv),
        .use_delay      (use_delay),
        .q_push         (q_push),
        .q_entry        (q_entry),
        .q_full         (q_full)
    );

    dcsh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    dcsh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_head     (q_head),
        .empty      (empty),
        .pop        (pop),
        .left_out   (left_out),
        .right_out  (right_out),
        .mute_led   (mute_led)
    );

endmodule
